// ===== design/pfe_pkg.sv =====
`timescale 1ns / 1ps

package pfe_pkg;

  // history pointer width, one history of 2**PTR_W entries per channel
  localparam int PTR_W  = 12;
  localparam int ADDR_W = PTR_W + 1;
  localparam int CNT_W  = 12;

  localparam logic [7:0] SILENCE = 8'd128;

  // input word
  typedef struct packed {
    logic [7:0] sample;
    logic       channel;
    logic       end_of_buffer;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] out_sample;
    logic       out_channel;
  } out_word_t;

  // classified sample handed from front to back
  typedef struct packed {
    logic [7:0]        sample;
    logic              echo;
    logic              use_self;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
  } cmd_t;

  // command queue status seen by the back end
  typedef struct packed {
    logic full;
    logic empty;
  } cq_status_t;

  // 128 + round_half_away(3*s/10), s = (x-128) + (prev-128)
  function automatic logic [7:0] echo_mix(input logic [7:0] x, input logic [7:0] prev);
    logic [9:0]  sum;
    logic        neg;
    logic [9:0]  diff;
    logic [9:0]  t;
    logic [9:0]  n;
    logic [17:0] prod;
    logic [6:0]  q;
    sum  = {2'b00, x} + {2'b00, prev};
    neg  = (sum < 10'd256);
    diff = neg ? (10'd256 - sum) : (sum - 10'd256);
    t    = diff * 10'd3;
    n    = t + 10'd5;
    // divide by ten: 205/2048 is exact in floor for n below 1024
    prod = {8'd0, n} * 18'd205;
    q    = prod[17:11];
    echo_mix = neg ? (SILENCE - {1'b0, q}) : (SILENCE + {1'b0, q});
  endfunction

endpackage

// ===== design/pcm8_feedback_echo.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// input     in         push / full          in_word  (sample, channel, end_of_buffer)
// result    out        pop / empty          out_word (out_sample, out_channel)
// config    in         cfg_we               cfg_data (delay_samples)
//
// one word per cycle sustained while the result queue is not full; an accepted word goes through
// the command queue, then history read, then echo math and history write into the result queue.
// the history read of each word sees the write of the word just ahead by forwarding,
// so a delay of one keeps full rate.
// reset clears pointers, counts, delay and both queues; history is not cleared.
// a full result queue stalls the back end, which backs up the command queue and then full.

module pcm8_feedback_echo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  pfe_pkg::in_word_t   in_word,
  input  logic                pop,
  output logic                empty,
  output pfe_pkg::out_word_t  out_word,
  input  logic                cfg_we,
  input  logic [11:0]         cfg_data
);

  pfe_pkg::cq_status_t cq_status;
  pfe_pkg::cmd_t       push_cmd;
  pfe_pkg::cmd_t       head_cmd;
  logic                cq_push;
  logic                cq_pop;

  // accept and classify
  pfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cq_status (cq_status),
    .cq_push   (cq_push),
    .cq_cmd    (push_cmd)
  );

  // decoupling queue
  pfe_cmd_queue u_cmd_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cq_push),
    .wr_cmd (push_cmd),
    .rd_en  (cq_pop),
    .rd_cmd (head_cmd),
    .status (cq_status)
  );

  // history, echo math and result queue
  pfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cq_status (cq_status),
    .cq_cmd    (head_cmd),
    .cq_pop    (cq_pop),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

endmodule

// ===== design/pfe_front.sv =====
`timescale 1ns / 1ps

module pfe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  pfe_pkg::in_word_t    in_word,
  input  logic                 cfg_we,
  input  logic [11:0]          cfg_data,
  input  pfe_pkg::cq_status_t  cq_status,
  output logic                 cq_push,
  output pfe_pkg::cmd_t        cq_cmd
);

  logic [11:0]                   delay_r;
  logic [pfe_pkg::PTR_W-1:0]     wp_r  [2];
  logic [pfe_pkg::CNT_W-1:0]     cnt_r [2];
  logic [pfe_pkg::PTR_W-1:0]     wp_sel;
  logic [pfe_pkg::CNT_W-1:0]     cnt_sel;
  logic [pfe_pkg::PTR_W-1:0]     wp_nxt;
  logic [pfe_pkg::CNT_W-1:0]     cnt_nxt;
  logic                          accept;

  assign full   = cq_status.full;
  assign accept = push && !cq_status.full;
  assign cq_push = accept;

  assign wp_sel  = wp_r[in_word.channel];
  assign cnt_sel = cnt_r[in_word.channel];

  // classify: pass through until the channel has seen delay samples
  always_comb begin
    cq_cmd.sample   = in_word.sample;
    cq_cmd.echo     = (cnt_sel >= delay_r);
    cq_cmd.use_self = (delay_r == 12'd0);
    cq_cmd.rd_addr  = {in_word.channel, wp_sel - delay_r};
    cq_cmd.wr_addr  = {in_word.channel, wp_sel};
  end

  // pointer and saturating count updates
  always_comb begin
    wp_nxt = wp_sel + {{(pfe_pkg::PTR_W - 1){1'b0}}, 1'b1};
    if (in_word.end_of_buffer) begin
      cnt_nxt = '0;
    end else if (cnt_sel != '1) begin
      cnt_nxt = cnt_sel + {{(pfe_pkg::CNT_W - 1){1'b0}}, 1'b1};
    end else begin
      cnt_nxt = cnt_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= '0;
      wp_r[0]  <= '0;
      wp_r[1]  <= '0;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
    end else begin
      if (cfg_we) begin
        delay_r <= cfg_data;
      end
      if (accept) begin
        wp_r[in_word.channel]  <= wp_nxt;
        cnt_r[in_word.channel] <= cnt_nxt;
      end
    end
  end

endmodule

// ===== design/pfe_cmd_queue.sv =====
`timescale 1ns / 1ps

module pfe_cmd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  pfe_pkg::cmd_t        wr_cmd,
  input  logic                 rd_en,
  output pfe_pkg::cmd_t        rd_cmd,
  output pfe_pkg::cq_status_t  status
);

  pfe_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic [1:0]    count_nxt;

  assign rd_cmd       = entry_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 2'd1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// ===== design/pfe_back.sv =====
`timescale 1ns / 1ps

module pfe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfe_pkg::cq_status_t  cq_status,
  input  pfe_pkg::cmd_t        cq_cmd,
  output logic                 cq_pop,
  output logic                 empty,
  input  logic                 pop,
  output pfe_pkg::out_word_t   out_word
);

  logic [7:0]         hist_mem [2**pfe_pkg::ADDR_W];
  logic [7:0]         rq_r;
  logic               fwd_r;
  logic [7:0]         fwd_y_r;
  logic               b2_valid_r;
  pfe_pkg::cmd_t      b2_cmd_r;
  logic               b2_done;
  logic               issue;
  logic [7:0]         prev;
  logic [7:0]         y;
  pfe_pkg::out_word_t oq_r [2];
  logic               oq_wr_ptr_r;
  logic               oq_rd_ptr_r;
  logic [1:0]         oq_count_r;
  logic               oq_full;
  logic               oq_pop;

  assign oq_full = (oq_count_r == 2'd2);
  assign empty   = (oq_count_r == 2'd0);
  assign oq_pop  = pop && !empty;
  assign out_word = oq_r[oq_rd_ptr_r];

  // second stage finishes when the result queue has room
  assign b2_done = b2_valid_r && !oq_full;
  assign issue   = !cq_status.empty && (!b2_valid_r || b2_done);
  assign cq_pop  = issue;

  // echo arithmetic, with the word just ahead forwarded if it hit the read address
  always_comb begin
    if (b2_cmd_r.use_self) begin
      prev = b2_cmd_r.sample;
    end else if (fwd_r) begin
      prev = fwd_y_r;
    end else begin
      prev = rq_r;
    end
    y = b2_cmd_r.echo ? pfe_pkg::echo_mix(b2_cmd_r.sample, prev) : b2_cmd_r.sample;
  end

  // history read port
  always_ff @(posedge clk) begin
    if (issue) begin
      rq_r <= hist_mem[cq_cmd.rd_addr];
    end
  end

  // history write port
  always_ff @(posedge clk) begin
    if (b2_done) begin
      hist_mem[b2_cmd_r.wr_addr] <= y;
    end
  end

  // stage two payload and forwarding registers
  always_ff @(posedge clk) begin
    if (issue) begin
      b2_cmd_r <= cq_cmd;
      fwd_r    <= b2_done && (b2_cmd_r.wr_addr == cq_cmd.rd_addr);
      fwd_y_r  <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
    end else if (issue) begin
      b2_valid_r <= 1'b1;
    end else if (b2_done) begin
      b2_valid_r <= 1'b0;
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_ptr_r <= 1'b0;
      oq_rd_ptr_r <= 1'b0;
      oq_count_r  <= '0;
    end else begin
      if (b2_done) begin
        oq_wr_ptr_r <= ~oq_wr_ptr_r;
      end
      if (oq_pop) begin
        oq_rd_ptr_r <= ~oq_rd_ptr_r;
      end
      if (b2_done && !oq_pop) begin
        oq_count_r <= oq_count_r + 2'd1;
      end else if (!b2_done && oq_pop) begin
        oq_count_r <= oq_count_r - 2'd1;
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (b2_done) begin
      oq_r[oq_wr_ptr_r].out_sample  <= y;
      oq_r[oq_wr_ptr_r].out_channel <= b2_cmd_r.wr_addr[pfe_pkg::ADDR_W-1];
    end
  end

endmodule

// ===== dv/pcm8_feedback_echo_test.sv =====
`timescale 1ns / 1ps

module pcm8_feedback_echo_test;

  localparam int HIST_DEPTH = 4096;
  localparam logic [11:0] COUNT_CAP = 12'd4095;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  pfe_pkg::in_word_t in_word = '0;
  logic pop = 1'b0;
  logic empty;
  pfe_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [11:0] cfg_data = '0;

  // echo model state: per-channel output history, write pointer, buffer count
  logic [7:0] echo_hist [2][HIST_DEPTH];
  logic [11:0] hist_wr_ptr [2];
  logic [11:0] buf_count [2];
  logic [11:0] delay_cfg = '0;

  pfe_pkg::in_word_t sample_backlog[$];
  pfe_pkg::out_word_t expected_echo[$];

  // stimulus shaping
  int send_idle_pct = 9;
  int recv_idle_pct = 76;
  int hold_req = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int buf_left [2];

  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int echo_count = 0;

  pcm8_feedback_echo DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .pop      (pop),
    .empty    (empty),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // work out the echoed sample for one accepted word
  task automatic echo_predict(input pfe_pkg::in_word_t w);
    int x;
    int prev;
    int s;
    int t;
    int r;
    logic [7:0] y;
    logic [11:0] p;
    logic [11:0] rd;
    logic ch;
    pfe_pkg::out_word_t res;
    ch = w.channel;
    x = w.sample;
    p = hist_wr_ptr[ch];
    if (buf_count[ch] < delay_cfg) begin
      y = w.sample;
    end else begin
      // zero delay mixes the sample with itself
      if (delay_cfg == 12'd0) begin
        prev = x;
      end else begin
        rd = p - delay_cfg;
        prev = echo_hist[ch][rd];
      end
      s = (x - 128) + (prev - 128);
      t = 3 * s;
      // halves round away from zero
      r = (t >= 0) ? (t + 5) / 10 : -((-t + 5) / 10);
      y = 8'(128 + r);
      echo_count++;
    end
    echo_hist[ch][p] = y;
    hist_wr_ptr[ch] = p + 12'd1;
    if (w.end_of_buffer) buf_count[ch] = '0;
    else if (buf_count[ch] != COUNT_CAP) buf_count[ch] = buf_count[ch] + 12'd1;
    res.out_sample = y;
    res.out_channel = ch;
    expected_echo.push_back(res);
  endtask

  task automatic queue_word(input int smp, input logic ch, input logic eob);
    pfe_pkg::in_word_t w;
    w.sample = 8'(smp);
    w.channel = ch;
    w.end_of_buffer = eob;
    sample_backlog.push_back(w);
  endtask

  // buffers mostly longer than the delay, some cut short
  task automatic queue_buffers(input int n, input int ch1_pct);
    int smp;
    int pick;
    logic ch;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      ch = ($urandom_range(99) < ch1_pct);
      if (buf_left[ch] == 0) begin
        if ($urandom_range(99) < 85)
          buf_left[ch] = $urandom_range(int'(delay_cfg) + 1, 3 * int'(delay_cfg) + 8);
        else
          buf_left[ch] = $urandom_range(1, int'(delay_cfg) + 1);
      end
      pick = $urandom_range(99);
      if (pick < 10) smp = 0;
      else if (pick < 20) smp = 255;
      else if (pick < 30) smp = 128;
      else smp = $urandom_range(255);
      queue_word(smp, ch, buf_left[ch] == 1);
      buf_left[ch]--;
    end
  endtask

  // wait until every queued word went in and every echo came back
  task automatic drain();
    while (sample_backlog.size() != 0 || push || expected_echo.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_delay(input logic [11:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    delay_cfg = value;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // sender: offer the next backlog word, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        echo_predict(in_word);
        words_in++;
      end
      if (!push || !full) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          in_word <= sample_backlog.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: check each popped word against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        words_out++;
        if (expected_echo.size() == 0) begin
          $display("%0t unexpected word: sample %0d channel %0d", $time,
                   out_word.out_sample, out_word.out_channel);
          errors++;
        end else begin
          if (out_word.out_sample !== expected_echo[0].out_sample) begin
            $display("%0t out_sample mismatch: expected %0d, actual %0d", $time,
                     expected_echo[0].out_sample, out_word.out_sample);
            errors++;
          end
          if (out_word.out_channel !== expected_echo[0].out_channel) begin
            $display("%0t out_channel mismatch: expected %0d, actual %0d", $time,
                     expected_echo[0].out_channel, out_word.out_channel);
            errors++;
          end
          void'(expected_echo.pop_front());
        end
      end
      // long hold-off so the block backs up into full
      if (hold_taken != hold_req) begin
        hold_taken <= hold_req;
        hold_left <= HOLD_CYCLES;
        pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d words in, %0d out", words_in, words_out);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int guard;
    for (int c = 0; c < 2; c++) begin
      hist_wr_ptr[c] = '0;
      buf_count[c] = '0;
      buf_left[c] = 0;
      for (int i = 0; i < HIST_DEPTH; i++) echo_hist[c][i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // extremes at the reset delay of zero, buffer ends on both channels
    @(negedge clk);
    queue_word(0, 1'b0, 1'b0);
    queue_word(255, 1'b0, 1'b0);
    queue_word(128, 1'b1, 1'b0);
    queue_word(127, 1'b1, 1'b0);
    queue_word(129, 1'b0, 1'b1);
    queue_word(0, 1'b1, 1'b1);
    queue_word(255, 1'b1, 1'b0);
    queue_word(1, 1'b0, 1'b0);
    drain();

    // delay of one: counts carry over from the first test, so every word echoes
    write_delay(12'd1);
    @(negedge clk);
    queue_word(128, 1'b0, 1'b0);
    queue_word(133, 1'b0, 1'b0);
    queue_word(121, 1'b0, 1'b1);
    queue_word(255, 1'b1, 1'b0);
    queue_word(0, 1'b1, 1'b0);
    drain();

    // random buffers, receiver mostly idle
    write_delay(12'd0);
    queue_buffers(120, 50);
    drain();

    write_delay(12'd1);
    @(negedge clk);
    hold_req++;
    queue_buffers(150, 50);
    drain();

    // sender mostly idle
    set_idling(76, 9);
    write_delay(12'($urandom_range(2, 40)));
    queue_buffers(150, 50);
    drain();
    write_delay(12'd3);
    queue_buffers(100, 30);
    drain();

    // no idling on either side
    set_idling(0, 0);
    write_delay(12'($urandom_range(41, 120)));
    queue_buffers(150, 50);
    drain();

    // longest delay: every word passes through
    write_delay(12'd4095);
    queue_buffers(60, 50);

    while (sample_backlog.size() != 0 || push) @(negedge clk);
    guard = 0;
    while (expected_echo.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    if (expected_echo.size() != 0) begin
      $display("%0t %0d expected words never came out", $time, expected_echo.size());
      errors += expected_echo.size();
    end
    repeat (10) @(posedge clk);

    $display("covered %0d words in, %0d words checked, %0d of them echoed", words_in,
             words_out, echo_count);
    $display("delays 0 to 4095, idling on each side, a long receiver hold, %0d errors",
             errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
